// ===== design/kcs_pkg.sv =====
package kcs_pkg;

  localparam int MAX_ALPHABET  = 24;
  localparam int MAX_KMER_LEN  = 12;
  localparam int POSITION_BITS = 32;

  localparam int CODE_W    = 56;
  localparam int TOK_W     = 5;
  localparam int K_W       = 4;
  localparam int START_W   = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ALPHA_W   = 3 * CFG_W;
  localparam int Q_DEPTH   = 2;
  localparam int WIN_IDX_W = $clog2(MAX_KMER_LEN);

  localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
  localparam logic [START_W-1:0]       START_MAX = '1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SIZE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN   = 3'd4;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [TOK_W-1:0]   token_index;
    logic               unknown_symbol;
    logic               kmer_ready;
    logic [CODE_W-1:0]  kmer_code;
    logic [START_W-1:0] kmer_start;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [TOK_W-1:0]         token;
    logic                     unknown;
    logic                     eos;
    logic [POSITION_BITS-1:0] pos;
  } tok_entry_t;

  // configuration view shared by front and back
  typedef struct packed {
    logic [ALPHA_W-1:0] chars;
    logic [TOK_W-1:0]   radix;
    logic [K_W-1:0]     klen;
    logic [CODE_W-1:0]  top_weight;
    logic               busy;
    logic               clear;
  } cfg_t;

  typedef enum logic {
    BK_IDLE,
    BK_FIN
  } bk_state_t;

endpackage

// ===== design/kcs_cfg.sv =====
module kcs_cfg
  import kcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  logic [CFG_W-1:0]        low_r, mid_r, high_r;
  logic [TOK_W-1:0]        size_r;
  logic [K_W-1:0]          klen_r;
  logic [CODE_W-1:0]       w_r, w_nxt;
  logic [K_W-1:0]          cnt_r;
  logic                    busy_r;
  logic                    wr_hit;
  logic [TOK_W-1:0]        radix;
  logic [K_W-1:0]          klen;
  logic [CODE_W+TOK_W-1:0] wprod;

  assign cfg_ready = 1'b1;

  assign wr_hit = cfg_valid && (cfg_index == REG_ALPHA_LOW || cfg_index == REG_ALPHA_MID ||
                                cfg_index == REG_ALPHA_HIGH || cfg_index == REG_ALPHA_SIZE ||
                                cfg_index == REG_KMER_LEN);

  // effective radix and k
  always_comb begin
    radix = (size_r > TOK_W'(MAX_ALPHABET)) ? TOK_W'(MAX_ALPHABET) : size_r;
    if (klen_r == '0) begin
      klen = K_W'(1);
    end else if (klen_r > K_W'(MAX_KMER_LEN)) begin
      klen = K_W'(MAX_KMER_LEN);
    end else begin
      klen = klen_r;
    end
  end

  // one radix step of A^(k-1) per cycle
  assign wprod = w_r * {{(CODE_W-TOK_W){1'b0}}, radix};
  assign w_nxt = wprod[CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      mid_r  <= '0;
      high_r <= '0;
      size_r <= TOK_W'(4);
      klen_r <= K_W'(4);
      w_r    <= CODE_W'(1);
      cnt_r  <= K_W'(1);
      busy_r <= 1'b1;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ALPHA_LOW:  low_r  <= cfg_data;
          REG_ALPHA_MID:  mid_r  <= cfg_data;
          REG_ALPHA_HIGH: high_r <= cfg_data;
          REG_ALPHA_SIZE: size_r <= cfg_data[TOK_W-1:0];
          REG_KMER_LEN:   klen_r <= cfg_data[K_W-1:0];
          default: ;
        endcase
      end
      if (wr_hit) begin
        w_r    <= CODE_W'(1);
        cnt_r  <= K_W'(1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r < klen) begin
          w_r   <= w_nxt;
          cnt_r <= cnt_r + K_W'(1);
        end else begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign cfg.chars      = {high_r, mid_r, low_r};
  assign cfg.radix      = radix;
  assign cfg.klen       = klen;
  assign cfg.top_weight = w_r;
  assign cfg.busy       = busy_r;
  assign cfg.clear      = wr_hit;

endmodule

// ===== design/kcs_front.sv =====
module kcs_front
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output tok_entry_t q_entry
);

  logic [POSITION_BITS-1:0] pos_r;
  logic [7:0]               sym, alt;
  logic                     is_letter;
  logic [MAX_ALPHABET-1:0]  hit_exact, hit_alt;
  logic [TOK_W-1:0]         tok;
  logic                     found;

  assign sym       = in_data.symbol;
  assign is_letter = (sym >= 8'h41 && sym <= 8'h5A) || (sym >= 8'h61 && sym <= 8'h7A);
  assign alt       = sym ^ 8'h20;

  always_comb begin
    for (int i = 0; i < MAX_ALPHABET; i++) begin
      hit_exact[i] = (i < int'(cfg.radix)) && (cfg.chars[i*8 +: 8] == sym);
      hit_alt[i]   = (i < int'(cfg.radix)) && is_letter && (cfg.chars[i*8 +: 8] == alt);
    end
  end

  // first exact match, else first opposite-case match; nul never matches
  always_comb begin
    tok   = '0;
    found = 1'b0;
    for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
      if (hit_alt[i]) begin
        tok   = TOK_W'(i);
        found = 1'b1;
      end
    end
    if (|hit_exact) begin
      for (int i = MAX_ALPHABET - 1; i >= 0; i--) begin
        if (hit_exact[i]) begin
          tok = TOK_W'(i);
        end
      end
      found = 1'b1;
    end
    if (sym == 8'h00) begin
      found = 1'b0;
      tok   = '0;
    end
  end

  assign in_ready = !cfg.busy && !q_full;
  assign q_push   = in_valid && in_ready;

  assign q_entry.token   = tok;
  assign q_entry.unknown = !found;
  assign q_entry.eos     = in_data.end_of_sequence;
  assign q_entry.pos     = pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (q_push) begin
      if (in_data.end_of_sequence) begin
        pos_r <= '0;
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + POSITION_BITS'(1);
      end
    end
  end

endmodule

// ===== design/kcs_fifo.sv =====
module kcs_fifo
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_entry_t din,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output tok_entry_t dout
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  tok_entry_t       mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/kcs_back.sv =====
module kcs_back
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  tok_entry_t q_entry,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  bk_state_t               st_r, st_nxt;
  tok_entry_t              ent_r;
  logic [CODE_W-1:0]       diff_r, diff_nxt;
  logic [CODE_W-1:0]       rc_r;
  logic [K_W-1:0]          vc_r;
  logic [TOK_W-1:0]        win_r [MAX_KMER_LEN];
  logic                    out_valid_r;
  out_item_t               out_data_r, res;
  logic                    commit;
  logic                    full_win;
  logic [TOK_W-1:0]        oldest;
  logic [CODE_W+TOK_W-1:0] sub_prod, mul_prod;
  logic [CODE_W-1:0]       rc_new;
  logic [K_W-1:0]          vc_new;
  logic                    ready_new;
  logic [POSITION_BITS-1:0] start_pos;
  logic [63:0]             start_ext;

  assign full_win = (vc_r >= cfg.klen);
  assign oldest   = win_r[WIN_IDX_W'(cfg.klen - K_W'(1))];
  assign sub_prod = cfg.top_weight * {{(CODE_W-TOK_W){1'b0}}, oldest};
  assign diff_nxt = full_win ? (rc_r - sub_prod[CODE_W-1:0]) : rc_r;

  assign mul_prod = diff_r * {{(CODE_W-TOK_W){1'b0}}, cfg.radix};
  assign rc_new   = mul_prod[CODE_W-1:0] + {{(CODE_W-TOK_W){1'b0}}, ent_r.token};
  assign vc_new   = full_win ? vc_r : vc_r + K_W'(1);
  assign ready_new = !ent_r.unknown && (vc_new >= cfg.klen);

  assign start_pos = ent_r.pos - POSITION_BITS'(cfg.klen - K_W'(1));
  assign start_ext = 64'(start_pos);

  always_comb begin
    res.token_index    = ent_r.unknown ? '0 : ent_r.token;
    res.unknown_symbol = ent_r.unknown;
    res.kmer_ready     = ready_new;
    res.kmer_code      = ready_new ? rc_new : '0;
    if (!ready_new) begin
      res.kmer_start = '0;
    end else if (ent_r.pos == POS_MAX || start_ext > 64'(START_MAX)) begin
      res.kmer_start = START_MAX;
    end else begin
      res.kmer_start = start_pos[START_W-1:0];
    end
  end

  always_comb begin
    st_nxt = st_r;
    q_pop  = 1'b0;
    commit = 1'b0;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          st_nxt = BK_FIN;
        end
      end
      BK_FIN: begin
        if (!out_valid_r || out_ready) begin
          commit = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r  <= q_entry;
      diff_r <= diff_nxt;
    end
    if (commit) begin
      out_data_r <= res;
      if (!ent_r.unknown) begin
        for (int i = MAX_KMER_LEN - 1; i > 0; i--) begin
          win_r[i] <= win_r[i-1];
        end
        win_r[0] <= ent_r.token;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r        <= '0;
      vc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg.clear) begin
        rc_r <= '0;
        vc_r <= '0;
      end else if (commit) begin
        if (ent_r.unknown || ent_r.eos) begin
          rc_r <= '0;
          vc_r <= '0;
        end else begin
          rc_r <= rc_new;
          vc_r <= vc_new;
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/kmer_code_streamer.sv =====
// rolling k-mer encoder: each input item carries one sequence byte; the block
// maps it to its alphabet index (first exact match, else first opposite-case
// match, nul always unknown) and returns exactly one result item per input
// item, in order. once k known tokens have arrived since the last restart the
// result carries the base-A code of the last k tokens (oldest most significant)
// and the position of the k-mer's first symbol; an unknown symbol flags the
// item and restarts the window, end_of_sequence clears window and position.
// the back end takes one item at a time: its idle state pops an item and
// takes the oldest token's weighted value off the running code, its finish
// state multiplies by the radix, adds the new token and waits out a stalled
// output before the next pop. the front classifies and numbers items and feeds
// a 2-deep queue, so input and output stall independently. after reset or any
// register write, in_ready stays low while A^(k-1) is built with one radix
// multiply per cycle. cfg_ready is always high; write only when idle.
module kmer_code_streamer
  import kcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t       cfg;
  logic       q_push, q_pop, q_full, q_valid;
  tok_entry_t q_din, q_dout;

  // config registers and top weight sequencer
  kcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // front: symbol lookup and position tracking
  kcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_din)
  );

  // decoupling queue of classified items
  kcs_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_dout)
  );

  // back: rolling code update and output register
  kcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_entry   (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/kcs_checker.sv =====
module kcs_checker
  import kcs_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input out_item_t            out_data,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // unknown symbol never completes a k-mer
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unknown_symbol |->
      !out_data.kmer_ready && out_data.token_index == '0)
    else $error("unknown symbol with token or k-mer");

  // incomplete k-mer carries zero code and start
  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.kmer_ready |->
      out_data.kmer_code == '0 && out_data.kmer_start == '0)
    else $error("code or start set without complete k-mer");

  // weight rebuild blocks input after a write
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_ALPHA_LOW || cfg_index == REG_ALPHA_MID ||
      cfg_index == REG_ALPHA_HIGH || cfg_index == REG_ALPHA_SIZE ||
      cfg_index == REG_KMER_LEN) |=> !in_ready)
    else $error("input taken during weight rebuild");

endmodule

bind kmer_code_streamer kcs_checker u_kcs_checker (.*);
